// ----- rtl/torf_pkg.sv -----
// ----------------------------------------------------------------------------
// torf_pkg
// Shared types, register indexes and constants for the clock offset filter
// ----------------------------------------------------------------------------
package torf_pkg;

	localparam logic [15:0] CRC_INIT = 16'hFFFF;
	localparam logic [15:0] CRC_POLY = 16'h1021;
	localparam logic [15:0] CRC_TOP  = 16'h8000;

	localparam logic [3:0] TIME_BYTES = 4'd8;
	localparam logic [3:0] LAST_BYTE  = 4'd9;

	localparam int          MUL_BITS     = 10;
	localparam int          MULI_W       = 4;
	localparam logic [9:0]  US_TO_NS     = 10'd1000;

	localparam logic REG_SYNC_EN = 1'b0;
	localparam logic REG_GAIN    = 1'b1;

	localparam logic [16:0] GAIN_RESET = 17'd6554;

	typedef struct packed {
		logic done;
		logic good;
	} frame_evt_t;

	function automatic logic [15:0] crc_byte(input logic [15:0] crc, input logic [7:0] b);
		logic [15:0] c;
		c = crc ^ {b, 8'h00};
		for (int k = 0; k < 8; k++) begin
			if ((c & CRC_TOP) != 16'h0000)
				c = {c[14:0], 1'b0} ^ CRC_POLY;
			else
				c = {c[14:0], 1'b0};
		end
		return c;
	endfunction

endpackage

// ----- rtl/torf_alu.sv -----
// ----------------------------------------------------------------------------
// torf_alu
// Shared add/subtract unit used by every arithmetic step of the sequencer
// ----------------------------------------------------------------------------
module torf_alu #(
	parameter int W = 82
) (
	input  logic [W-1:0] a,
	input  logic [W-1:0] b,
	input  logic         sub,
	output logic [W-1:0] sum
);

	logic [W-1:0] b_eff;

	assign b_eff = sub ? ~b : b;
	assign sum   = a + b_eff + {{(W-1){1'b0}}, sub};

endmodule

// ----- rtl/torf_frame.sv -----
// ----------------------------------------------------------------------------
// torf_frame
// Reply frame receiver: byte counter, device time assembly and crc check
// ----------------------------------------------------------------------------
module torf_frame (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 byte_en,
	input  logic [7:0]           data_byte,
	output torf_pkg::frame_evt_t evt,
	output logic [63:0]          device_time_us
);

	logic [3:0]  idx_q;
	logic [15:0] crc_q;
	logic [63:0] dev_q;
	logic [7:0]  chk_lo_q;
	logic        done_q;
	logic        good_q;
	logic [63:0] dev_next;
	logic [5:0]  sh;

	assign sh       = {idx_q[2:0], 3'b000};
	assign dev_next = (idx_q == 4'd0) ? {56'd0, data_byte}
		: (dev_q | ({56'd0, data_byte} << sh));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			idx_q  <= 4'd0;
			crc_q  <= torf_pkg::CRC_INIT;
			done_q <= 1'b0;
			good_q <= 1'b0;
		end else begin
			done_q <= 1'b0;
			if (byte_en) begin
				if (idx_q < torf_pkg::TIME_BYTES) begin
					crc_q <= torf_pkg::crc_byte(crc_q, data_byte);
					idx_q <= idx_q + 4'd1;
				end else if (idx_q == torf_pkg::TIME_BYTES) begin
					idx_q <= idx_q + 4'd1;
				end else begin
					idx_q  <= 4'd0;
					crc_q  <= torf_pkg::CRC_INIT;
					done_q <= 1'b1;
					good_q <= ({data_byte, chk_lo_q} == crc_q);
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (byte_en && idx_q < torf_pkg::TIME_BYTES)
			dev_q <= dev_next;
		if (byte_en && idx_q == torf_pkg::TIME_BYTES)
			chk_lo_q <= data_byte;
	end

	assign evt.done       = done_q;
	assign evt.good       = good_q;
	assign device_time_us = dev_q;

`ifndef SYNTHESIS
	a_idx_range: assert property (@(posedge clk) disable iff (!arst_n)
		idx_q <= torf_pkg::LAST_BYTE)
		else $error("frame byte index out of range");
	a_done_restart: assert property (@(posedge clk) disable iff (!arst_n)
		done_q |-> (idx_q == 4'd0 || idx_q == 4'd1) && $past(byte_en))
		else $error("frame end without restart");
	a_done_from_last: assert property (@(posedge clk) disable iff (!arst_n)
		(byte_en && idx_q == torf_pkg::LAST_BYTE) |=> done_q && crc_q == torf_pkg::CRC_INIT)
		else $error("last byte did not close the frame");
`endif

endmodule

// ----- rtl/time_offset_reply_filter_core.sv -----
// ----------------------------------------------------------------------------
// time_offset_reply_filter_core
// Two-way clock offset estimator with crc checked reply frames and an
// exponential average of the offset
// ----------------------------------------------------------------------------
//  channel  | direction | payload
//  s_*      | in        | tuser: opcode; tdata: data_byte, time_ns
//  m_*      | out       | tdata: offset_ns, smoothed_offset_ns
//  apb      | config    | 0x0 sync_enable, 0x4 smoothing_gain
//
//  a request is taken in IDLE, which it does not leave; a reply byte sends it to CHECK
//  a good tenth byte runs CHECK, MID, MUL, OFF and WRITE, and once the average
//  is seeded also DIFF, BLEND, ADDOLD and ROUND before WRITE, all on one adder
//  the result register holds one finished transfer; a held result stalls input
//  at the end of the next good frame only; reset sets control defaults, clears average
// ----------------------------------------------------------------------------
module time_offset_reply_filter_core #(
	parameter int GAIN_FRACTION_BITS = 16
) (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         s_tvalid,
	output logic         s_tready,
	input  logic [71:0]  s_tdata,   // data_byte[7:0], time_ns[70:8], zero[71]
	input  logic         s_tuser,   // opcode
	output logic         m_tvalid,
	input  logic         m_tready,
	output logic [127:0] m_tdata,   // offset_ns[63:0], smoothed_offset_ns[127:64]
	input  logic         psel,
	input  logic         penable,
	input  logic         pwrite,
	input  logic [2:0]   paddr,
	input  logic [31:0]  pwdata,
	output logic [31:0]  prdata,
	output logic         pready
);

	localparam int F        = GAIN_FRACTION_BITS;
	localparam int W        = 66 + F;
	localparam int GW       = F + 1;
	localparam int CW       = (GW > 17) ? GW : 17;
	localparam int GI_W     = $clog2(GW);
	localparam int ITER_MAX = (GW > 10) ? GW : 10;
	localparam int CNT_W    = $clog2(ITER_MAX);

	localparam logic [3:0] ST_IDLE   = 4'd0;
	localparam logic [3:0] ST_CHECK  = 4'd1;
	localparam logic [3:0] ST_MID    = 4'd2;
	localparam logic [3:0] ST_MUL    = 4'd3;
	localparam logic [3:0] ST_OFF    = 4'd4;
	localparam logic [3:0] ST_DIFF   = 4'd5;
	localparam logic [3:0] ST_BLEND  = 4'd6;
	localparam logic [3:0] ST_ADDOLD = 4'd7;
	localparam logic [3:0] ST_ROUND  = 4'd8;
	localparam logic [3:0] ST_WRITE  = 4'd9;

	logic [3:0]       state_q;
	logic [CNT_W-1:0] cnt_q;
	logic             sync_en_q;
	logic [16:0]      gain_q;
	logic [62:0]      req_q;
	logic [62:0]      t3_q;
	logic [62:0]      mid_q;
	logic [63:0]      offset_q;
	logic [63:0]      smooth_q;
	logic             have_prev_q;
	logic [64:0]      diff_q;
	logic [GW-1:0]    g_q;
	logic [W-1:0]     acc_q;
	logic             m_tvalid_q;
	logic [63:0]      out_off_q;
	logic [63:0]      out_smooth_q;

	logic                 s_xfer;
	logic                 cfg_wr;
	logic                 out_load;
	torf_pkg::frame_evt_t evt;
	logic [63:0]          dev_us;
	logic [W-1:0]         alu_a;
	logic [W-1:0]         alu_b;
	logic                 alu_sub;
	logic [W-1:0]         alu_sum;
	logic [CW-1:0]        gain_ext;
	logic [CW-1:0]        one_ext;
	logic [GW-1:0]        g_sat;
	logic                 mul_bit;
	logic                 g_bit;

	assign s_tready = (state_q == ST_IDLE);
	assign s_xfer   = s_tvalid && s_tready;
	assign pready   = 1'b1;
	assign cfg_wr   = psel && penable && pwrite && pready;
	assign prdata   = (paddr[2] == torf_pkg::REG_GAIN) ? {15'd0, gain_q} : {31'd0, sync_en_q};
	assign out_load = (state_q == ST_WRITE) && (!m_tvalid_q || m_tready);

	assign gain_ext = CW'(gain_q);
	assign one_ext  = CW'(1) << F;
	assign g_sat    = (gain_ext > one_ext) ? one_ext[GW-1:0] : gain_ext[GW-1:0];
	assign mul_bit  = torf_pkg::US_TO_NS[cnt_q[torf_pkg::MULI_W-1:0]];
	assign g_bit    = g_q[cnt_q[GI_W-1:0]];

	torf_frame u_frame (
		.clk            (clk),
		.arst_n         (arst_n),
		.byte_en        (s_xfer && s_tuser),
		.data_byte      (s_tdata[7:0]),
		.evt            (evt),
		.device_time_us (dev_us)
	);

	torf_alu #(.W(W)) u_alu (
		.a   (alu_a),
		.b   (alu_b),
		.sub (alu_sub),
		.sum (alu_sum)
	);

	always_comb begin
		alu_a   = acc_q;
		alu_b   = '0;
		alu_sub = 1'b0;
		case (state_q)
			ST_MID: begin
				alu_a = {{(W-63){1'b0}}, req_q};
				alu_b = {{(W-63){1'b0}}, t3_q};
			end
			ST_MUL: begin
				alu_a   = {acc_q[W-2:0], 1'b0};
				alu_b   = mul_bit ? {{(W-64){1'b0}}, dev_us} : '0;
				alu_sub = mul_bit;
			end
			ST_OFF: begin
				alu_b = {{(W-63){1'b0}}, mid_q};
			end
			ST_DIFF: begin
				alu_a   = {{(W-64){offset_q[63]}}, offset_q};
				alu_b   = {{(W-64){smooth_q[63]}}, smooth_q};
				alu_sub = 1'b1;
			end
			ST_BLEND: begin
				alu_a = {acc_q[W-2:0], 1'b0};
				alu_b = g_bit ? {{(W-65){diff_q[64]}}, diff_q} : '0;
			end
			ST_ADDOLD: begin
				alu_b = {{(W-64-F){smooth_q[63]}}, smooth_q, {F{1'b0}}};
			end
			ST_ROUND: begin
				alu_b = acc_q[W-1] ? {{(W-F){1'b0}}, {F{1'b1}}} : '0;
			end
			default: begin
				alu_a = acc_q;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			cnt_q       <= '0;
			sync_en_q   <= 1'b1;
			gain_q      <= torf_pkg::GAIN_RESET;
			req_q       <= '0;
			smooth_q    <= '0;
			have_prev_q <= 1'b0;
			m_tvalid_q  <= 1'b0;
		end else begin
			if (cfg_wr) begin
				if (paddr[2] == torf_pkg::REG_SYNC_EN)
					sync_en_q <= pwdata[0];
				else
					gain_q <= pwdata[16:0];
			end
			if (out_load)
				m_tvalid_q <= 1'b1;
			else if (m_tready)
				m_tvalid_q <= 1'b0;
			case (state_q)
				ST_IDLE: begin
					if (s_xfer) begin
						if (!s_tuser) begin
							if (sync_en_q)
								req_q <= s_tdata[70:8];
						end else begin
							state_q <= ST_CHECK;
						end
					end
				end
				ST_CHECK: begin
					if (evt.done && evt.good)
						state_q <= ST_MID;
					else
						state_q <= ST_IDLE;
				end
				ST_MID: begin
					cnt_q   <= CNT_W'(torf_pkg::MUL_BITS - 1);
					state_q <= ST_MUL;
				end
				ST_MUL: begin
					if (cnt_q == '0)
						state_q <= ST_OFF;
					else
						cnt_q <= cnt_q - 1'b1;
				end
				ST_OFF: begin
					if (have_prev_q) begin
						state_q <= ST_DIFF;
					end else begin
						smooth_q    <= alu_sum[63:0];
						have_prev_q <= 1'b1;
						state_q     <= ST_WRITE;
					end
				end
				ST_DIFF: begin
					cnt_q   <= CNT_W'(F);
					state_q <= ST_BLEND;
				end
				ST_BLEND: begin
					if (cnt_q == '0)
						state_q <= ST_ADDOLD;
					else
						cnt_q <= cnt_q - 1'b1;
				end
				ST_ADDOLD: begin
					state_q <= ST_ROUND;
				end
				ST_ROUND: begin
					smooth_q <= alu_sum[F+63:F];
					state_q  <= ST_WRITE;
				end
				ST_WRITE: begin
					if (out_load)
						state_q <= ST_IDLE;
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (s_xfer && s_tuser)
			t3_q <= s_tdata[70:8];
		case (state_q)
			ST_MID: begin
				mid_q <= alu_sum[63:1];
				acc_q <= '0;
			end
			ST_MUL: acc_q <= alu_sum;
			ST_OFF: offset_q <= alu_sum[63:0];
			ST_DIFF: begin
				diff_q <= alu_sum[64:0];
				g_q    <= g_sat;
				acc_q  <= '0;
			end
			ST_BLEND: acc_q <= alu_sum;
			ST_ADDOLD: acc_q <= alu_sum;
			ST_WRITE: begin
				if (out_load) begin
					out_off_q    <= offset_q;
					out_smooth_q <= smooth_q;
				end
			end
			default: begin
				acc_q <= acc_q;
			end
		endcase
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = {out_smooth_q, out_off_q};

`ifndef SYNTHESIS
	a_good_frame_starts: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_CHECK && evt.done && evt.good) |=> state_q == ST_MID)
		else $error("good frame did not start the offset sequence");
	a_prev_sticky: assert property (@(posedge clk) disable iff (!arst_n)
		!$fell(have_prev_q))
		else $error("average seed flag cleared");
	a_result_from_write: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(m_tvalid_q) |-> $past(state_q == ST_WRITE))
		else $error("result raised outside the write step");
	a_write_holds: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_WRITE && m_tvalid_q && !m_tready) |=> state_q == ST_WRITE)
		else $error("result lost while output stalled");
`endif

endmodule
